// File: rtl/bw_pkg.sv
// Shared constants for the barycentric weight block.
// No dependencies; bw_out_if, bw_back and the top level use this package.
`timescale 1ns / 1ps

package bw_pkg;

	// result weight width (signed, fraction bits set at the top level)
	localparam int OUT_BITS = 24;
	// one weight per triangle corner
	localparam int LANES = 3;

endpackage

// File: rtl/bw_in_if.sv
// Input channel: one query point and three triangle corners per beat.
// Depends on nothing; the coordinate width is a parameter.
`timescale 1ns / 1ps

interface bw_in_if #(
	parameter int CB = 16
);
	logic              valid;
	logic              ready;
	logic signed [CB-1:0] point_x;
	logic signed [CB-1:0] point_y;
	logic signed [CB-1:0] corner_a_x;
	logic signed [CB-1:0] corner_a_y;
	logic signed [CB-1:0] corner_b_x;
	logic signed [CB-1:0] corner_b_y;
	logic signed [CB-1:0] corner_c_x;
	logic signed [CB-1:0] corner_c_y;

	modport source (output valid, point_x, point_y, corner_a_x, corner_a_y,
		corner_b_x, corner_b_y, corner_c_x, corner_c_y, input ready);
	modport sink (input valid, point_x, point_y, corner_a_x, corner_a_y,
		corner_b_x, corner_b_y, corner_c_x, corner_c_y, output ready);
endinterface

// File: rtl/bw_out_if.sv
// Output channel: three weights and two flags per beat.
// Depends on bw_pkg for the weight width.
`timescale 1ns / 1ps

interface bw_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bw_pkg::OUT_BITS-1:0]  weight_a;
	logic signed [bw_pkg::OUT_BITS-1:0]  weight_b;
	logic signed [bw_pkg::OUT_BITS-1:0]  weight_c;
	logic                                degenerate;
	logic                                saturated;

	modport source (output valid, weight_a, weight_b, weight_c, degenerate, saturated,
		input ready);
	modport sink (input valid, weight_a, weight_b, weight_c, degenerate, saturated,
		output ready);
endinterface

// File: rtl/bw_front.sv
// Front end: accepts input beats and forms the four doubled cross products
// (full area and three sub-areas) in a three-stage pipeline. Uses bw_in_if.
`timescale 1ns / 1ps

module bw_front #(
	parameter int CB = 16,
	parameter int CW = 2 * (CB + 1) + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	bw_in_if.sink           req,
	output logic            push_valid,
	input  logic            push_ready,
	output logic [4*CW-1:0] push_data
);
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] dif;
	logic signed [DW-1:0] dif_s1 [10];
	logic signed [PW-1:0] prd_s2 [8];
	logic signed [CW-1:0] crs_s3 [4];

	// whole front advances together; stalls only when the queue is full
	assign en        = !v_s3 || push_ready;
	assign req.ready = en;

	// differences: 0..5 corners minus point, 6..9 b and c minus a
	logic signed [DW-1:0] dn [10];
	always_comb begin
		dn[0] = DW'(req.corner_a_x) - DW'(req.point_x);
		dn[1] = DW'(req.corner_a_y) - DW'(req.point_y);
		dn[2] = DW'(req.corner_b_x) - DW'(req.point_x);
		dn[3] = DW'(req.corner_b_y) - DW'(req.point_y);
		dn[4] = DW'(req.corner_c_x) - DW'(req.point_x);
		dn[5] = DW'(req.corner_c_y) - DW'(req.point_y);
		dn[6] = DW'(req.corner_b_x) - DW'(req.corner_a_x);
		dn[7] = DW'(req.corner_b_y) - DW'(req.corner_a_y);
		dn[8] = DW'(req.corner_c_x) - DW'(req.corner_a_x);
		dn[9] = DW'(req.corner_c_y) - DW'(req.corner_a_y);
	end
	assign dif = dn[0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload: differences, products, cross products
	always_ff @(posedge clk) begin
		if (en) begin
			dif_s1[0] <= dif;
			for (int i = 1; i < 10; i++) dif_s1[i] <= dn[i];
			prd_s2[0] <= PW'(dif_s1[6]) * PW'(dif_s1[9]);
			prd_s2[1] <= PW'(dif_s1[8]) * PW'(dif_s1[7]);
			prd_s2[2] <= PW'(dif_s1[2]) * PW'(dif_s1[5]);
			prd_s2[3] <= PW'(dif_s1[4]) * PW'(dif_s1[3]);
			prd_s2[4] <= PW'(dif_s1[4]) * PW'(dif_s1[1]);
			prd_s2[5] <= PW'(dif_s1[0]) * PW'(dif_s1[5]);
			prd_s2[6] <= PW'(dif_s1[0]) * PW'(dif_s1[3]);
			prd_s2[7] <= PW'(dif_s1[2]) * PW'(dif_s1[1]);
			for (int k = 0; k < 4; k++)
				crs_s3[k] <= CW'(prd_s2[2*k]) - CW'(prd_s2[2*k+1]);
		end
	end

	// beat to queue: area in the low slot, then sub-areas a, b, c
	assign push_valid = v_s3;
	always_comb begin
		for (int k = 0; k < 4; k++) push_data[k*CW +: CW] = crs_s3[k];
	end
endmodule

// File: rtl/bw_fifo.sv
// Small decoupling queue between front and back end.
// No dependencies.
`timescale 1ns / 1ps

module bw_fifo #(
	parameter int W  = 140,
	parameter int AW = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int DEPTH = 1 << AW;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign push_ready = cnt_q < (AW+1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end
endmodule

// File: rtl/bw_back.sv
// Back end: pipelined restoring division, one quotient bit per stage for
// each of the three lanes, then sign, saturation and the output register.
// Depends on bw_pkg and bw_out_if.
`timescale 1ns / 1ps

module bw_back #(
	parameter int CW = 35,
	parameter int F  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  logic [4*CW-1:0] pop_data,
	bw_out_if.source        rsp
);
	import bw_pkg::*;

	localparam int OB = OUT_BITS;
	localparam int SH = OB - F;
	localparam logic [OB-1:0] MAXNEG = OB'(1) << (OB - 1);
	localparam logic [OB-1:0] MAXPOS = MAXNEG - 1'b1;

	logic en;

	// stage registers; stage 0 is setup, stage k+1 holds k+1 quotient bits
	logic          vld_s [OB+1];
	logic          dgn_s [OB+1];
	logic [CW-1:0] den_s [OB+1];
	logic [CW-1:0] num_s [OB+1][LANES];
	logic [CW-1:0] rem_s [OB+1][LANES];
	logic [OB-1:0] quo_s [OB+1][LANES];
	logic          neg_s [OB+1][LANES];
	logic          ovf_s [OB+1][LANES];

	logic                 out_valid_q, out_dgn_q, out_sat_q;
	logic signed [OB-1:0] out_w_q [LANES];

	// single enable: everything moves unless the output beat is held
	assign en        = !out_valid_q || rsp.ready;
	assign pop_ready = en;

	// setup: magnitudes, sign, and the integer-part overflow check
	logic signed [CW-1:0] den_in;
	logic [CW-1:0]        dmag;
	logic signed [CW-1:0] num_in [LANES];
	logic [CW-1:0]        nmag [LANES];
	logic [CW-1:0]        hi [LANES];
	always_comb begin
		den_in = pop_data[0 +: CW];
		dmag   = den_in[CW-1] ? CW'(-den_in) : CW'(den_in);
		for (int l = 0; l < LANES; l++) begin
			num_in[l] = pop_data[(l+1)*CW +: CW];
			nmag[l]   = num_in[l][CW-1] ? CW'(-num_in[l]) : CW'(num_in[l]);
			hi[l]     = nmag[l] >> SH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= OB; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pop_valid;
			for (int k = 0; k < OB; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dgn_s[0] <= dmag == '0;
			den_s[0] <= dmag;
			for (int l = 0; l < LANES; l++) begin
				num_s[0][l] <= nmag[l];
				rem_s[0][l] <= hi[l];
				quo_s[0][l] <= '0;
				neg_s[0][l] <= num_in[l][CW-1] ^ den_in[CW-1];
				ovf_s[0][l] <= hi[l] >= dmag;
			end
		end
	end

	// division steps
	for (genvar k = 0; k < OB; k++) begin : g_step
		localparam int I = OB - 1 - k;
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic        nb;
			logic [CW:0] trial;
			logic        take;
			if (I >= F) begin : g_bit
				assign nb = num_s[k][l][I-F];
			end else begin : g_zero
				assign nb = 1'b0;
			end
			assign trial = {rem_s[k][l], nb};
			assign take  = trial >= {1'b0, den_s[k]};
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[k+1][l] <= num_s[k][l];
					rem_s[k+1][l] <= take ? CW'(trial - {1'b0, den_s[k]}) : CW'(trial);
					quo_s[k+1][l] <= {quo_s[k][l][OB-2:0], take};
					neg_s[k+1][l] <= neg_s[k][l];
					ovf_s[k+1][l] <= ovf_s[k][l];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dgn_s[k+1] <= dgn_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	// sign and saturation
	logic signed [OB-1:0] w_fin [LANES];
	logic                 sat_fin;
	always_comb begin
		logic [OB-1:0] q;
		logic          big;
		sat_fin = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			q   = quo_s[OB][l];
			big = ovf_s[OB][l];
			if (dgn_s[OB]) begin
				w_fin[l] = '0;
			end else if (neg_s[OB][l] && (big || q != '0)) begin
				if (big || q > MAXNEG) begin
					sat_fin  = 1'b1;
					w_fin[l] = MAXNEG;
				end else begin
					w_fin[l] = -q;
				end
			end else if (big || q > MAXPOS) begin
				sat_fin  = 1'b1;
				w_fin[l] = MAXPOS;
			end else begin
				w_fin[l] = q;
			end
		end
		if (dgn_s[OB]) sat_fin = 1'b0;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[OB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_dgn_q <= dgn_s[OB];
			out_sat_q <= sat_fin;
			for (int l = 0; l < LANES; l++) out_w_q[l] <= w_fin[l];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.weight_a   = out_w_q[0];
	assign rsp.weight_b   = out_w_q[1];
	assign rsp.weight_c   = out_w_q[2];
	assign rsp.degenerate = out_dgn_q;
	assign rsp.saturated  = out_sat_q;
endmodule

// File: rtl/barycentric_weights_2d.sv
// Top level of the barycentric weight block: front end, queue, back end.
// Depends on bw_pkg, bw_in_if, bw_out_if, bw_front, bw_fifo, bw_back.
//
//   channel  dir  payload
//   req      in   point_x/y, corner_a_x/y, corner_b_x/y, corner_c_x/y
//   rsp      out  weight_a/b/c, degenerate, saturated
//
// One beat per cycle sustained while rsp is ready. A beat passes the front stages,
// the queue, then the back end (setup, one divider stage per quotient bit, output register).
// arst_n clears all valid bits and queue pointers; no clearing pass.
// Front and back stall independently; the 4-entry queue absorbs the gap.
`timescale 1ns / 1ps

module barycentric_weights_2d #(
	parameter int COORD_BITS       = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	bw_in_if.sink    req,
	bw_out_if.source rsp
);
	import bw_pkg::*;

	localparam int CW = 2 * (COORD_BITS + 1) + 1;
	localparam logic signed [OUT_BITS-1:0] WMAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic signed [OUT_BITS-1:0] WMIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [4*CW-1:0] push_data, pop_data;

	bw_front #(.CB(COORD_BITS), .CW(CW)) u_front (
		.clk, .arst_n, .req,
		.push_valid, .push_ready, .push_data
	);

	bw_fifo #(.W(4*CW), .AW(2)) u_fifo (
		.clk, .arst_n,
		.push_valid, .push_ready, .push_data,
		.pop_valid, .pop_ready, .pop_data
	);

	bw_back #(.CW(CW), .F(WEIGHT_FRAC_BITS)) u_back (
		.clk, .arst_n,
		.pop_valid, .pop_ready, .pop_data, .rsp
	);

	// zero area gives zero weights and no saturation
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.degenerate |-> !rsp.saturated && rsp.weight_a == '0
			&& rsp.weight_b == '0 && rsp.weight_c == '0)
		else $error("degenerate beat with nonzero weights or saturation");

	// a clamp always leaves some weight at a range limit
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.saturated |-> rsp.weight_a == WMAX || rsp.weight_a == WMIN
			|| rsp.weight_b == WMAX || rsp.weight_b == WMIN
			|| rsp.weight_c == WMAX || rsp.weight_c == WMIN)
		else $error("saturated flag without a clamped weight");

	// front holds its beat while the queue is full
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> push_valid && $stable(push_data))
		else $error("front dropped a beat while the queue was full");
endmodule
